// ----- design/uue_pkg.sv -----
package uue_pkg;

    // Line buffer depth in bytes.
    localparam int BUFFER_BYTES = 64;
    localparam int BUF_AW = $clog2(BUFFER_BYTES);

    localparam logic [5:0] MAX_DECLARED_RESET = 6'd45;

    // Result status codes.
    localparam logic [2:0] ST_BYTE       = 3'd0;
    localparam logic [2:0] ST_TERMINATOR = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_BAD_CHAR   = 3'd3;
    localparam logic [2:0] ST_TOO_MANY   = 3'd4;
    localparam logic [2:0] ST_TRUNCATED  = 3'd5;
    localparam logic [2:0] ST_TRAILING   = 3'd6;

    localparam logic [7:0] CHAR_BACKTICK = 8'h60;
    localparam logic [7:0] CHAR_LOW      = 8'h20;
    localparam logic [7:0] CHAR_HIGH     = 8'h5F;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_TAB      = 8'h09;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } uue_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       last;
    } uue_out_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_char;
        logic take_eol;
        logic load_status;
        logic rd_en;
    } uue_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] verdict;
        logic       out_free;
        logic       q_valid;
        logic       rd_last;
    } uue_stat_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b0;
        s.value = 6'd0;
        if (c == CHAR_BACKTICK) begin
            s.valid = 1'b1;
        end else if (c >= CHAR_LOW && c <= CHAR_HIGH) begin
            s.valid = 1'b1;
            s.value = 6'(c - CHAR_LOW);
        end
        return s;
    endfunction

    // Characters of payload for n bytes: ceil(n/3) groups of four.
    // The divide by three is a multiply by 171/512, exact for this range.
    function automatic logic [6:0] payload_chars(input logic [5:0] n);
        logic [6:0]  n2;
        logic [15:0] prod;
        logic [4:0]  groups;
        n2 = {1'b0, n} + 7'd2;
        prod = 16'(n2) * 16'd171;
        groups = prod[13:9];
        return {groups, 2'b00};
    endfunction

endpackage

// ----- design/uue_ctrl.sv -----
module uue_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_end_of_line,
    output logic               s_ready,
    input  uue_pkg::uue_stat_t dp_stat,
    output uue_pkg::uue_cmd_t  dp_cmd
);
    import uue_pkg::*;

    typedef enum logic [1:0] {
        S_LINE,
        S_STATUS,
        S_READ,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_LINE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_end_of_line) begin
                        dp_cmd.take_eol = 1'b1;
                        state_next = (dp_stat.verdict == ST_BYTE) ? S_READ : S_STATUS;
                    end else begin
                        dp_cmd.take_char = 1'b1;
                    end
                end
            end
            S_STATUS: begin
                if (dp_stat.out_free) begin
                    dp_cmd.load_status = 1'b1;
                    state_next = S_LINE;
                end
            end
            S_READ: begin
                if (!dp_stat.q_valid || dp_stat.out_free) begin
                    dp_cmd.rd_en = 1'b1;
                    if (dp_stat.rd_last) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                // Wait until the last byte has moved into the output register.
                if (!dp_stat.q_valid || dp_stat.out_free) begin
                    state_next = S_LINE;
                end
            end
            default: begin
                state_next = S_LINE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LINE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/uue_dpath.sv -----
module uue_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [5:0]        cfg_wr_data,
    input  uue_pkg::uue_in_t  s_data,
    input  logic              m_ready,
    output logic              m_valid,
    output uue_pkg::uue_out_t m_data,
    input  uue_pkg::uue_cmd_t dp_cmd,
    output uue_pkg::uue_stat_t dp_stat
);
    import uue_pkg::*;

    logic [5:0] max_declared_reg;
    logic [6:0] char_pos_reg,      char_pos_next;
    logic [5:0] declared_reg,      declared_next;
    logic [6:0] payload_chars_reg, payload_chars_next;
    logic [1:0] phase_reg,         phase_next;
    logic [5:0] prev_sextet_reg,   prev_sextet_next;
    logic [5:0] buf_count_reg,     buf_count_next;
    logic [2:0] length_status_reg, length_status_next;
    logic       bad_reg,           bad_next;
    logic       trailing_reg,      trailing_next;

    logic [2:0] eol_status_reg;
    logic [5:0] drain_cnt_reg;
    logic [5:0] rd_ptr_reg;
    logic       q_valid_reg;
    logic       q_last_reg;
    logic [7:0] mem_q_reg;
    logic       out_valid_reg;
    uue_out_t   out_reg;

    logic [7:0] line_buffer [BUFFER_BYTES];

    sextet_t    sx;
    logic [5:0] s_val;
    logic [7:0] byte_val;
    logic       wr_en;
    logic [2:0] verdict;
    logic       out_free;
    logic       out_load_q;

    assign sx    = sextet_of(s_data.char_code);
    assign s_val = sx.valid ? sx.value : 6'd0;

    always_comb begin
        case (phase_reg)
            2'd1:    byte_val = {prev_sextet_reg, s_val[5:4]};
            2'd2:    byte_val = {prev_sextet_reg[3:0], s_val[5:2]};
            2'd3:    byte_val = {prev_sextet_reg[1:0], s_val};
            default: byte_val = 8'd0;
        endcase
    end

    // Line state update on a character, and clearing of the line state on end of line.
    always_comb begin
        char_pos_next      = char_pos_reg;
        declared_next      = declared_reg;
        payload_chars_next = payload_chars_reg;
        phase_next         = phase_reg;
        prev_sextet_next   = prev_sextet_reg;
        buf_count_next     = buf_count_reg;
        length_status_next = length_status_reg;
        bad_next           = bad_reg;
        trailing_next      = trailing_reg;
        wr_en              = 1'b0;
        if (dp_cmd.take_eol) begin
            char_pos_next      = 7'd0;
            declared_next      = 6'd0;
            payload_chars_next = 7'd0;
            phase_next         = 2'd0;
            prev_sextet_next   = 6'd0;
            buf_count_next     = 6'd0;
            length_status_next = ST_BYTE;
            bad_next           = 1'b0;
            trailing_next      = 1'b0;
        end else if (dp_cmd.take_char) begin
            if (char_pos_reg == 7'd0) begin
                if (!sx.valid) begin
                    length_status_next = ST_BAD_CHAR;
                end else begin
                    declared_next      = sx.value;
                    payload_chars_next = payload_chars(sx.value);
                    if (sx.value == 6'd0) begin
                        length_status_next = ST_TERMINATOR;
                    end else if (sx.value > max_declared_reg
                                 || 7'(sx.value) > 7'(BUFFER_BYTES)) begin
                        length_status_next = ST_TOO_MANY;
                    end else begin
                        length_status_next = ST_BYTE;
                    end
                end
            end else if (length_status_reg == ST_BYTE) begin
                if (char_pos_reg <= payload_chars_reg) begin
                    if (!sx.valid) begin
                        bad_next = 1'b1;
                    end
                    phase_next       = phase_reg + 2'd1;
                    prev_sextet_next = s_val;
                    // Each sextet after the first of a group completes one byte.
                    if (phase_reg != 2'd0 && buf_count_reg < declared_reg
                        && 7'(buf_count_reg) < 7'(BUFFER_BYTES)) begin
                        wr_en          = 1'b1;
                        buf_count_next = buf_count_reg + 6'd1;
                    end
                end else if (s_data.char_code != CHAR_SPACE
                             && s_data.char_code != CHAR_TAB) begin
                    trailing_next = 1'b1;
                end
            end
            if (char_pos_reg != 7'h7F) begin
                char_pos_next = char_pos_reg + 7'd1;
            end
        end
    end

    // Verdict on the line as it stands, used when end of line is taken.
    always_comb begin
        if (char_pos_reg == 7'd0) begin
            verdict = ST_EMPTY;
        end else if (length_status_reg != ST_BYTE) begin
            verdict = length_status_reg;
        end else if (char_pos_reg <= payload_chars_reg) begin
            verdict = ST_TRUNCATED;
        end else if (trailing_reg) begin
            verdict = ST_TRAILING;
        end else if (bad_reg) begin
            verdict = ST_BAD_CHAR;
        end else begin
            verdict = ST_BYTE;
        end
    end

    assign out_free   = !out_valid_reg || m_ready;
    assign out_load_q = q_valid_reg && out_free;

    assign dp_stat.verdict  = verdict;
    assign dp_stat.out_free = out_free;
    assign dp_stat.q_valid  = q_valid_reg;
    assign dp_stat.rd_last  = (rd_ptr_reg == drain_cnt_reg - 6'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_declared_reg  <= MAX_DECLARED_RESET;
            char_pos_reg      <= 7'd0;
            declared_reg      <= 6'd0;
            payload_chars_reg <= 7'd0;
            phase_reg         <= 2'd0;
            prev_sextet_reg   <= 6'd0;
            buf_count_reg     <= 6'd0;
            length_status_reg <= ST_BYTE;
            bad_reg           <= 1'b0;
            trailing_reg      <= 1'b0;
            eol_status_reg    <= ST_BYTE;
            drain_cnt_reg     <= 6'd0;
            rd_ptr_reg        <= 6'd0;
            q_valid_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_declared_reg <= cfg_wr_data;
            end
            char_pos_reg      <= char_pos_next;
            declared_reg      <= declared_next;
            payload_chars_reg <= payload_chars_next;
            phase_reg         <= phase_next;
            prev_sextet_reg   <= prev_sextet_next;
            buf_count_reg     <= buf_count_next;
            length_status_reg <= length_status_next;
            bad_reg           <= bad_next;
            trailing_reg      <= trailing_next;
            if (dp_cmd.take_eol) begin
                eol_status_reg <= verdict;
                drain_cnt_reg  <= declared_reg;
                rd_ptr_reg     <= 6'd0;
            end else if (dp_cmd.rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 6'd1;
            end
            if (dp_cmd.rd_en) begin
                q_valid_reg <= 1'b1;
            end else if (out_load_q) begin
                q_valid_reg <= 1'b0;
            end
            if (dp_cmd.load_status || out_load_q) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Line buffer: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_buffer[buf_count_reg[BUF_AW-1:0]] <= byte_val;
        end
        if (dp_cmd.rd_en) begin
            mem_q_reg  <= line_buffer[rd_ptr_reg[BUF_AW-1:0]];
            q_last_reg <= dp_stat.rd_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_status) begin
            out_reg.data_byte <= 8'd0;
            out_reg.status    <= eol_status_reg;
            out_reg.last      <= 1'b1;
        end else if (out_load_q) begin
            out_reg.data_byte <= mem_q_reg;
            out_reg.status    <= ST_BYTE;
            out_reg.last      <= q_last_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- design/uue_line_decoder_core.sv -----
// Channel      Direction  Handshake          Transaction payload
// s_ (input)   in         s_valid / s_ready  uue_in_t: char_code, end_of_line
// m_ (result)  out        m_valid / m_ready  uue_out_t: data_byte, status, last
// cfg_         in         cfg_wr_en          cfg_wr_data: max_declared, no wait
//
// Character transactions are always accepted in line intake, so a line streams in
// at one character per cycle; each decoded byte is written to the line buffer as
// its sextet arrives. After the end-of-line transaction the input is held off: a
// status line then loads its result once the result register is free, and a valid
// line of n bytes drains at one byte per cycle while m_ready is high, through the
// buffer's registered read port.
// Reset (aresetn, synchronous, active low) clears all control and line state and
// sets max_declared to 45; the line buffer needs no clearing pass.
// The result register lets the next line start while the last result still waits.
module uue_line_decoder_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  uue_pkg::uue_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output uue_pkg::uue_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [5:0]        cfg_wr_data
);
    import uue_pkg::*;

    // Commands and status between the sequencer and the decode datapath.
    uue_cmd_t  dp_cmd;
    uue_stat_t dp_stat;

    // The controller walks through line intake, status emission and buffer drain.
    uue_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_end_of_line (s_data.end_of_line),
        .s_ready       (s_ready),
        .dp_stat       (dp_stat),
        .dp_cmd        (dp_cmd)
    );

    // The datapath holds the sextet decoder, the line checks, the line buffer and
    // the result register.
    uue_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat)
    );

endmodule
